>>> sv/matrix_transpose_buffer_macros.svh
// Assertion macros for the corner-turn buffer controller
`ifndef MATRIX_TRANSPOSE_BUFFER_MACROS_SVH
`define MATRIX_TRANSPOSE_BUFFER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MTB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("corner-turn check failed");

// next-cycle implication
`define MTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("corner-turn sequencing check failed");

`endif

>>> sv/mtb_pkg.sv
// Shared constants and types for the corner-turn buffer
package mtb_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int ELEM_WIDTH  = 64;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int ROW_IW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_IW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // controller to datapath command bundle
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
        logic                last;
    } mtb_cmd_t;

endpackage

>>> sv/matrix_transpose_buffer.sv
// Corner-turn buffer top level: controller plus element store datapath
//
//  channel   handshake                 payload
//  request   start / busy              cmd, element_in
//  result    result_strobe (1 cycle)   element_out, is_last
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load request leaves busy low, and the next request may follow.
// For a read request, the store is read at the accepting edge and
// the result shows in the following cycle with busy high, set by the store's
// registered read port. A read before the matrix is full gives no result.
// Reset clears counters and sets both dimensions to one; stored words are kept.
// The receiver cannot stall; config is refused only while a result shows.
module matrix_transpose_buffer
    import mtb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [DATA_W-1:0]    element_in,
    output logic                 result_strobe,
    output logic [DATA_W-1:0]    element_out,
    output logic                 is_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    mtb_cmd_t ctl;

    mtb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctl           (ctl)
    );

    mtb_datapath u_datapath (
        .clk         (clk),
        .ctl         (ctl),
        .element_in  (element_in),
        .element_out (element_out),
        .is_last     (is_last)
    );

endmodule

>>> sv/mtb_datapath.sv
// Element store, registered read port and result registers
module mtb_datapath
    import mtb_pkg::*;
(
    input  logic                  clk,
    input  mtb_cmd_t              ctl,
    input  logic [DATA_W-1:0]     element_in,
    output logic [DATA_W-1:0]     element_out,
    output logic                  is_last
);

    logic [ELEM_WIDTH-1:0] store_mem [STORE_DEPTH];
    logic [ELEM_WIDTH-1:0] rd_data_reg;
    logic                  last_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[ctl.wr_addr] <= element_in[ELEM_WIDTH-1:0];
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[ctl.rd_addr];
            last_reg    <= ctl.last;
        end
    end

    assign element_out = DATA_W'(rd_data_reg);
    assign is_last     = last_reg;

endmodule

>>> sv/mtb_ctrl.sv
// Controller: config registers, load/read counters and result sequencing
`include "matrix_transpose_buffer_macros.svh"

module mtb_ctrl
    import mtb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cmd,
    output logic                 busy,
    output logic                 result_strobe,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output mtb_cmd_t             ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SHOW = 1'b1;

    logic               state_reg, state_next;
    logic [DIM_W-1:0]   row_cfg_reg, row_cfg_next;
    logic [DIM_W-1:0]   col_cfg_reg, col_cfg_next;
    logic [COUNT_W-1:0] load_count_reg, load_count_next;
    logic [ROW_IW-1:0]  read_row_reg, read_row_next;
    logic [COL_IW-1:0]  read_col_reg, read_col_next;
    logic               emitting_reg, emitting_next;

    logic [DIM_W-1:0]         rows, cols;
    logic [COUNT_W-1:0]       total;
    logic [2*DIM_W-1:0]       total_full;
    logic [2*DIM_W-1:0]       addr_full;
    logic                     accept, cfg_fire;
    logic                     do_load, do_read;
    logic                     row_end, col_end;

    // zero acts as one, anything past the maximum as the maximum
    always_comb
    begin
        if (row_cfg_reg == '0)
            rows = DIM_W'(1);
        else if (row_cfg_reg > DIM_W'(MAX_ROWS))
            rows = DIM_W'(MAX_ROWS);
        else
            rows = row_cfg_reg;
        if (col_cfg_reg == '0)
            cols = DIM_W'(1);
        else if (col_cfg_reg > DIM_W'(MAX_COLS))
            cols = DIM_W'(MAX_COLS);
        else
            cols = col_cfg_reg;
    end

    assign total_full = (2*DIM_W)'(rows) * (2*DIM_W)'(cols);
    assign total      = COUNT_W'(total_full);

    assign busy      = (state_reg == ST_SHOW);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign do_load   = accept && (cmd == CMD_LOAD) && !emitting_reg && (load_count_reg < total);
    assign do_read   = accept && (cmd == CMD_READ) && emitting_reg;

    assign row_end = (DIM_W'(read_row_reg) == rows - DIM_W'(1));
    assign col_end = (DIM_W'(read_col_reg) == cols - DIM_W'(1));

    // row-major address of element (row, column)
    assign addr_full = (2*DIM_W)'(read_row_reg) * (2*DIM_W)'(cols) + (2*DIM_W)'(read_col_reg);

    always_comb
    begin
        ctl.wr_en   = do_load;
        ctl.wr_addr = load_count_reg[STORE_AW-1:0];
        ctl.rd_en   = do_read;
        ctl.rd_addr = addr_full[STORE_AW-1:0];
        ctl.last    = row_end && col_end;
    end

    always_comb
    begin
        state_next      = state_reg;
        row_cfg_next    = row_cfg_reg;
        col_cfg_next    = col_cfg_reg;
        load_count_next = load_count_reg;
        read_row_next   = read_row_reg;
        read_col_next   = read_col_reg;
        emitting_next   = emitting_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (do_read)
                    state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_load)
        begin
            load_count_next = load_count_reg + COUNT_W'(1);
            if (load_count_next >= total)
                emitting_next = 1'b1;
        end

        if (do_read)
        begin
            if (row_end && col_end)
            begin
                load_count_next = '0;
                read_row_next   = '0;
                read_col_next   = '0;
                emitting_next   = 1'b0;
            end
            else if (!row_end)
            begin
                read_row_next = read_row_reg + ROW_IW'(1);
            end
            else
            begin
                read_row_next = '0;
                read_col_next = read_col_reg + COL_IW'(1);
            end
        end

        // a register write restarts loading; stored words stay
        if (cfg_fire && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT))
        begin
            if (cfg_index == REG_ROW_COUNT)
                row_cfg_next = cfg_data;
            else
                col_cfg_next = cfg_data;
            load_count_next = '0;
            read_row_next   = '0;
            read_col_next   = '0;
            emitting_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_cfg_reg    <= DIM_W'(1);
            col_cfg_reg    <= DIM_W'(1);
            load_count_reg <= '0;
            read_row_reg   <= '0;
            read_col_reg   <= '0;
            emitting_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_cfg_reg    <= row_cfg_next;
            col_cfg_reg    <= col_cfg_next;
            load_count_reg <= load_count_next;
            read_row_reg   <= read_row_next;
            read_col_reg   <= read_col_next;
            emitting_reg   <= emitting_next;
        end
    end

    assign result_strobe = (state_reg == ST_SHOW);

    `MTB_ASSERT_NEXT(a_read_gives_result, do_read, result_strobe)
    `MTB_ASSERT_NOW(a_load_bounded, 1'b1, load_count_reg <= total)
    `MTB_ASSERT_NOW(a_emit_only_full, emitting_reg, load_count_reg == total)
    `MTB_ASSERT_NOW(a_row_in_range, 1'b1, DIM_W'(read_row_reg) < rows)

endmodule
